// ===== sv/psu_pkg.sv =====
package psu_pkg;

    // image geometry and line store size
    localparam int TILE_SIZE  = 256;
    localparam int LINE_DEPTH = TILE_SIZE * 4;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(LINE_DEPTH + 1);
    localparam int ROW_W      = $clog2(TILE_SIZE);

    // bytes-per-pixel register
    localparam int          CH_W     = 3;
    localparam logic [2:0]  CH_RGB   = 3'd3;
    localparam logic [2:0]  CH_RESET = 3'd4;

    // row strides in bytes
    localparam logic [COL_W-1:0] STRIDE_RGB  = COL_W'(3 * TILE_SIZE);
    localparam logic [COL_W-1:0] STRIDE_RGBA = COL_W'(4 * TILE_SIZE);

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // row filter types
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // one finished pixel
    typedef struct packed {
        logic [31:0] pixel_argb;
        logic        filter_error;
        logic        last_pixel;
    } result_t;

endpackage

// ===== sv/psu_if.sv =====
// inflated stream bytes
interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

// reconstructed pixels
interface psu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;
    logic        filter_error;
    logic        last_pixel;

    modport source (output valid, output pixel_argb, output filter_error,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_argb, input filter_error,
                  input last_pixel, output ready);
endinterface

// bytes-per-pixel register write
interface psu_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] channels_per_pixel;

    modport source (output valid, output channels_per_pixel, input ready);
    modport sink (input valid, input channels_per_pixel, output ready);
endinterface

// ===== sv/psu_ram.sv =====
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/psu_predict.sv =====
module psu_predict (
    input  psu_pkg::filter_t filt,
    input  logic [7:0]       left,
    input  logic [7:0]       up,
    input  logic [7:0]       up_left,
    output logic [7:0]       pred
);

    import psu_pkg::*;

    logic signed [9:0] a_s;
    logic signed [9:0] b_s;
    logic signed [9:0] c_s;
    logic signed [9:0] pa_s;
    logic signed [9:0] pb_s;
    logic signed [9:0] pc_s;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [8:0]        avg_sum;
    logic [7:0]        paeth;

    // paeth distances: p-a = b-c, p-b = a-c, p-c = a+b-2c
    always_comb
    begin
        a_s  = signed'({2'b00, left});
        b_s  = signed'({2'b00, up});
        c_s  = signed'({2'b00, up_left});
        pa_s = b_s - c_s;
        pb_s = a_s - c_s;
        pc_s = a_s + b_s - c_s - c_s;
        pa   = pa_s[9] ? unsigned'(-pa_s) : unsigned'(pa_s);
        pb   = pb_s[9] ? unsigned'(-pb_s) : unsigned'(pb_s);
        pc   = pc_s[9] ? unsigned'(-pc_s) : unsigned'(pc_s);
        if (pa <= pb && pa <= pc)
        begin
            paeth = left;
        end
        else if (pb <= pc)
        begin
            paeth = up;
        end
        else
        begin
            paeth = up_left;
        end
    end

    // predictor select
    always_comb
    begin
        avg_sum = {1'b0, left} + {1'b0, up};
        unique case (filt)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = up;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end

endmodule

// ===== sv/psu_out_buf.sv =====
module psu_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psu_pkg::result_t  push_data,
    output logic              full,
    psu_out_if.source         pixel_out
);

    import psu_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop = main_valid_reg && pixel_out.ready;

    // valid flags of the two entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!push)
            begin
                main_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // payload of the two entries
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

    assign full                   = skid_valid_reg;
    assign pixel_out.valid        = main_valid_reg;
    assign pixel_out.pixel_argb   = main_reg.pixel_argb;
    assign pixel_out.filter_error = main_reg.filter_error;
    assign pixel_out.last_pixel   = main_reg.last_pixel;

endmodule

// ===== sv/png_scanline_unfilter.sv =====
// channel     dir  payload                                   notes
// byte_in     in   data_byte[7:0], image_start               one stream byte per request
// pixel_out   out  pixel_argb[31:0], filter_error, last_pixel one pixel per request
// cfg_wr      in   channels_per_pixel[2:0]                   always ready
//
// one byte is taken per cycle unless byte_in stalls; a pixel is registered into the output buffer with its last byte
// the up byte comes from a line store read one byte ahead, so its registered
// read is ready the cycle after the previous byte
// a two-entry output buffer keeps the input side moving; byte_in stalls only
// while both entries wait on pixel_out
// reset clears position, histories, error and sets four bytes per pixel
module png_scanline_unfilter (
    input  logic      clk,
    input  logic      rst_n,
    psu_in_if.sink    byte_in,
    psu_out_if.source pixel_out,
    psu_cfg_if.sink   cfg_wr
);

    import psu_pkg::*;

    logic [CH_W-1:0]  cfg_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       chan_reg, chan_next;
    logic [31:0]      left_reg, left_next;
    logic [31:0]      ul_reg, ul_next;
    logic [23:0]      asm_reg, asm_next;
    filter_t          filt_reg, filt_next;
    logic             err_reg, err_next;
    logic             done_reg, done_next;

    logic             in_fire;
    logic             buf_full;
    logic             is_rgb;
    logic [COL_W-1:0] stride;
    logic [COL_W-1:0] col_e;
    logic [ROW_W-1:0] row_e;
    logic [1:0]       chan_e;
    logic [31:0]      left_e;
    logic [31:0]      ul_e;
    logic [23:0]      asm_e;
    filter_t          filt_e;
    logic             err_e;
    logic             done_e;

    logic [7:0]       left_byte;
    logic [7:0]       ul_byte;
    logic [7:0]       up_byte;
    logic [7:0]       ram_rdata;
    logic [7:0]       pred;
    logic [7:0]       recon;
    logic [COL_W-1:0] col_m1;
    logic [COL_W-1:0] rd_col_m1;
    logic             sample;
    logic             row_end;
    logic             final_row;
    logic             emit;
    logic             res_push;
    result_t          res;

    function automatic logic [7:0] data_add(input logic [7:0] a, input logic [7:0] b);
        data_add = a + b;
    endfunction

    assign in_fire       = byte_in.valid && byte_in.ready;
    assign byte_in.ready = !buf_full;
    assign cfg_wr.ready  = 1'b1;

    // bytes-per-pixel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CH_RESET;
        end
        else if (cfg_wr.valid)
        begin
            cfg_reg <= cfg_wr.channels_per_pixel;
        end
    end

    assign is_rgb = (cfg_reg == CH_RGB);
    assign stride = is_rgb ? STRIDE_RGB : STRIDE_RGBA;

    // state as seen by this byte, cleared by an image start
    always_comb
    begin
        if (byte_in.image_start)
        begin
            col_e  = '0;
            row_e  = '0;
            chan_e = '0;
            left_e = '0;
            ul_e   = '0;
            asm_e  = '0;
            filt_e = FILT_NONE;
            err_e  = 1'b0;
            done_e = 1'b0;
        end
        else
        begin
            col_e  = col_reg;
            row_e  = row_reg;
            chan_e = chan_reg;
            left_e = left_reg;
            ul_e   = ul_reg;
            asm_e  = asm_reg;
            filt_e = filt_reg;
            err_e  = err_reg;
            done_e = done_reg;
        end
    end

    // neighbors of the current sample
    assign left_byte = is_rgb ? left_e[23:16] : left_e[31:24];
    assign ul_byte   = is_rgb ? ul_e[23:16] : ul_e[31:24];
    assign up_byte   = (row_e != '0) ? ram_rdata : 8'd0;

    psu_predict u_predict (
        .filt    (filt_e),
        .left    (left_byte),
        .up      (up_byte),
        .up_left (ul_byte),
        .pred    (pred)
    );

    assign recon     = data_add(byte_in.data_byte, pred);
    assign col_m1    = col_e - COL_W'(1);
    assign sample    = in_fire && !done_e && (col_e != '0);
    assign row_end   = (col_e >= stride);
    assign final_row = (row_e == ROW_W'(TILE_SIZE - 1));
    assign emit      = is_rgb ? (chan_e >= 2'd2) : (chan_e == 2'd3);

    // next state of the scanline walk
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        chan_next = chan_reg;
        left_next = left_reg;
        ul_next   = ul_reg;
        asm_next  = asm_reg;
        filt_next = filt_reg;
        err_next  = err_reg;
        done_next = done_reg;
        if (in_fire)
        begin
            col_next  = col_e;
            row_next  = row_e;
            chan_next = chan_e;
            left_next = left_e;
            ul_next   = ul_e;
            asm_next  = asm_e;
            filt_next = filt_e;
            err_next  = err_e;
            done_next = done_e;
            if (!done_e)
            begin
                if (col_e == '0)
                begin
                    // filter byte opens the row
                    if (byte_in.data_byte > 8'(FILT_PAETH))
                    begin
                        err_next  = 1'b1;
                        filt_next = FILT_NONE;
                    end
                    else
                    begin
                        filt_next = filter_t'(byte_in.data_byte[2:0]);
                    end
                    col_next = COL_W'(1);
                end
                else
                begin
                    col_next  = col_e + COL_W'(1);
                    left_next = {left_e[23:0], recon};
                    ul_next   = {ul_e[23:0], up_byte};
                    if (emit)
                    begin
                        chan_next = '0;
                        asm_next  = '0;
                    end
                    else
                    begin
                        chan_next = chan_e + 2'd1;
                        asm_next  = {asm_e[15:0], recon};
                    end
                    if (row_end)
                    begin
                        col_next  = '0;
                        chan_next = '0;
                        left_next = '0;
                        ul_next   = '0;
                        asm_next  = '0;
                        if (final_row)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            row_next = row_e + ROW_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            chan_reg <= '0;
            left_reg <= '0;
            ul_reg   <= '0;
            asm_reg  <= '0;
            filt_reg <= FILT_NONE;
            err_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            chan_reg <= chan_next;
            left_reg <= left_next;
            ul_reg   <= ul_next;
            asm_reg  <= asm_next;
            filt_reg <= filt_next;
            err_reg  <= err_next;
            done_reg <= done_next;
        end
    end

    // line store: write this column, read the column of the next byte
    assign rd_col_m1 = col_next - COL_W'(1);

    psu_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (sample),
        .waddr (col_m1[ADDR_W-1:0]),
        .wdata (recon),
        .raddr (rd_col_m1[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // pixel result
    always_comb
    begin
        if (err_e)
        begin
            res.pixel_argb = 32'd0;
        end
        else if (is_rgb)
        begin
            res.pixel_argb = {ALPHA_OPAQUE, asm_e[15:0], recon};
        end
        else
        begin
            res.pixel_argb = {recon, asm_e};
        end
        res.filter_error = err_e;
        res.last_pixel   = row_end && final_row;
    end

    assign res_push = sample && emit;

    psu_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .full      (buf_full),
        .pixel_out (pixel_out)
    );

endmodule

// ===== sv/psu_checker.sv =====
module psu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] pixel_argb,
    input logic        filter_error,
    input logic        last_pixel
);

    // an errored pixel carries no color
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filter_error |-> pixel_argb == 32'd0)
        else $error("errored pixel has nonzero color");

    // a new pixel needs a byte request in the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("pixel appeared without a byte request");

    // input stalls only behind a waiting pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && $past(out_valid && !out_ready))
        else $error("byte input stalled with no pixel waiting");

    // a stalled pixel holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_argb)
            && $stable(filter_error) && $stable(last_pixel))
        else $error("stalled pixel changed");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_in.valid),
    .in_ready     (byte_in.ready),
    .out_valid    (pixel_out.valid),
    .out_ready    (pixel_out.ready),
    .pixel_argb   (pixel_out.pixel_argb),
    .filter_error (pixel_out.filter_error),
    .last_pixel   (pixel_out.last_pixel)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import psu_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic [7:0] CORNER_SAMPLES [4] = '{8'h00, 8'hff, 8'h80, 8'h7f};
    localparam logic [7:0] OPENING_FILTERS [7] = '{
        8'(FILT_NONE), 8'(FILT_SUB), 8'(FILT_UP), 8'(FILT_AVG),
        8'(FILT_PAETH), 8'hff, 8'(FILT_NONE)
    };

    // pixel reconstruction and the pixels still owed by the block
    class pixel_scoreboard;
        bit [7:0]    line_mem [LINE_DEPTH];
        bit [31:0]   left_bytes;
        bit [31:0]   upper_left_bytes;
        bit [23:0]   partial_pixel;
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned chan_pos;
        filter_t     row_filter;
        bit          err_sticky;
        bit          image_complete;
        bit [2:0]    bytes_per_px;
        result_t     want_pixels [$];
        int          mismatches;

        function new();
            foreach (line_mem[i])
                line_mem[i] = 8'd0;
            restart_row();
            row_pos        = 0;
            row_filter     = FILT_NONE;
            err_sticky     = 1'b0;
            image_complete = 1'b0;
            bytes_per_px   = CH_RESET;
            mismatches     = 0;
        endfunction

        function void restart_row();
            col_pos          = 0;
            chan_pos         = 0;
            left_bytes       = '0;
            upper_left_bytes = '0;
            partial_pixel    = '0;
        endfunction

        function void set_channels(bit [2:0] v);
            bytes_per_px = v;
        endfunction

        function bit [7:0] paeth_choice(bit [7:0] a, bit [7:0] b, bit [7:0] c);
            int p;
            int pa;
            int pb;
            int pc;
            p  = int'(a) + int'(b) - int'(c);
            pa = (p >= int'(a)) ? p - int'(a) : int'(a) - p;
            pb = (p >= int'(b)) ? p - int'(b) : int'(b) - p;
            pc = (p >= int'(c)) ? p - int'(c) : int'(c) - p;
            if (pa <= pb && pa <= pc)
                return a;
            return (pb <= pc) ? b : c;
        endfunction

        // one accepted stream byte request
        function void take_byte(bit [7:0] b, bit start);
            int unsigned ch;
            int unsigned stride;
            int unsigned x;
            bit [7:0]    left;
            bit [7:0]    up;
            bit [7:0]    ul;
            bit [7:0]    pred;
            bit [7:0]    recon;
            bit          row_end;
            bit          last_row;
            bit [31:0]   argb;
            result_t     px;
            ch     = (bytes_per_px == CH_RGB) ? 3 : 4;
            stride = TILE_SIZE * ch;
            if (start)
            begin
                restart_row();
                row_pos        = 0;
                row_filter     = FILT_NONE;
                err_sticky     = 1'b0;
                image_complete = 1'b0;
            end
            if (image_complete)
                return;

            // filter type byte opens each row
            if (col_pos == 0)
            begin
                if (int'(b) > int'(FILT_PAETH))
                begin
                    err_sticky = 1'b1;
                    row_filter = FILT_NONE;
                end
                else
                    row_filter = filter_t'(b[2:0]);
                col_pos = 1;
                return;
            end

            // neighbors and prediction
            x    = col_pos - 1;
            left = left_bytes[8*(ch-1) +: 8];
            ul   = upper_left_bytes[8*(ch-1) +: 8];
            up   = (row_pos > 0 && x < LINE_DEPTH) ? line_mem[x] : 8'd0;
            case (row_filter)
                FILT_SUB:   pred = left;
                FILT_UP:    pred = up;
                FILT_AVG:   pred = 8'((9'(left) + 9'(up)) >> 1);
                FILT_PAETH: pred = paeth_choice(left, up, ul);
                default:    pred = 8'd0;
            endcase
            recon = b + pred;

            if (x < LINE_DEPTH)
                line_mem[x] = recon;
            left_bytes       = {left_bytes[23:0], recon};
            upper_left_bytes = {upper_left_bytes[23:0], up};

            col_pos++;
            row_end  = (col_pos >= stride + 1);
            last_row = (row_pos + 1 >= TILE_SIZE);

            // pixel assembly
            if (chan_pos + 1 >= ch)
            begin
                if (ch == 3)
                    argb = {ALPHA_OPAQUE, partial_pixel[15:0], recon};
                else
                    argb = {recon, partial_pixel};
                px.pixel_argb   = err_sticky ? 32'd0 : argb;
                px.filter_error = err_sticky;
                px.last_pixel   = row_end && last_row;
                want_pixels     = {want_pixels, px};
                chan_pos      = 0;
                partial_pixel = '0;
            end
            else
            begin
                partial_pixel = {partial_pixel[15:0], recon};
                chan_pos      = (chan_pos + 1) & 3;
            end

            if (row_end)
            begin
                restart_row();
                if (last_row)
                    image_complete = 1'b1;
                else
                    row_pos++;
            end
        endfunction

        task flag_mismatch(string msg);
            $display("tb: mismatch: %s", msg);
            mismatches++;
        endtask

        // one accepted pixel request
        task check_pixel(result_t got);
            result_t want;
            if (want_pixels.size() == 0)
            begin
                flag_mismatch($sformatf("pixel %h with none pending", got.pixel_argb));
                return;
            end
            want = want_pixels.pop_front();
            if (got.pixel_argb !== want.pixel_argb)
                flag_mismatch($sformatf("pixel_argb %h, want %h",
                                        got.pixel_argb, want.pixel_argb));
            if (got.filter_error !== want.filter_error)
                flag_mismatch($sformatf("filter_error %b, want %b",
                                        got.filter_error, want.filter_error));
            if (got.last_pixel !== want.last_pixel)
                flag_mismatch($sformatf("last_pixel %b, want %b",
                                        got.last_pixel, want.last_pixel));
        endtask
    endclass

    logic clk;
    logic rst_n;

    psu_in_if  byte_if ();
    psu_out_if pix_if ();
    psu_cfg_if cfg_if ();

    pixel_scoreboard sb;
    result_t         seen_pixel;
    bit              idle_on;
    bit              idle_allowed;
    int              hold_left;
    int              cur_ch;
    int              cycle_count;

    png_scanline_unfilter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_if),
        .pixel_out (pix_if),
        .cfg_wr    (cfg_if)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // pixel receiver with random stalls and long hold-offs
    initial
    begin
        int stall_left;
        stall_left = 0;
        pix_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                pix_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                pix_if.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                pix_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end
            else
                pix_if.ready <= 1'b1;
        end
    end

    // watch requests on all channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                seen_pixel.pixel_argb   = pix_if.pixel_argb;
                seen_pixel.filter_error = pix_if.filter_error;
                seen_pixel.last_pixel   = pix_if.last_pixel;
                sb.check_pixel(seen_pixel);
            end
            if (byte_if.valid && byte_if.ready)
                sb.take_byte(byte_if.data_byte, byte_if.image_start);
            if (cfg_if.valid && cfg_if.ready)
                sb.set_channels(cfg_if.channels_per_pixel);
        end
    end

    function automatic logic [7:0] rand_sample();
        if ($urandom_range(0, 7) == 0)
            return CORNER_SAMPLES[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // one stream byte request, with an optional gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic s);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        byte_if.valid       <= 1'b1;
        byte_if.data_byte   <= b;
        byte_if.image_start <= s;
        do
            @(posedge clk);
        while (!byte_if.ready);
    endtask

    // filter byte then n samples
    task automatic send_row(input bit first, input int n, input bit allow_bad);
        logic [7:0] f;
        idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
        if (allow_bad && $urandom_range(0, 15) == 0)
            f = 8'($urandom_range(5, 255));
        else
            f = 8'($urandom_range(0, 4));
        send_byte(f, first);
        repeat (n) send_byte(rand_sample(), 1'b0);
    endtask

    // full rows then a cut-off row of tail_bytes samples
    task automatic send_image(input int full_rows, input int tail_bytes, input bit allow_bad);
        int stride;
        stride = (cur_ch == 3) ? int'(STRIDE_RGB) : int'(STRIDE_RGBA);
        for (int r = 0; r < full_rows; r++)
            send_row(r == 0, stride, allow_bad);
        if (tail_bytes > 0 || full_rows == 0)
            send_row(full_rows == 0, tail_bytes, allow_bad);
    endtask

    // let the block go idle
    task automatic wait_quiet();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.want_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_channels(input logic [2:0] v);
        wait_quiet();
        cfg_if.valid              <= 1'b1;
        cfg_if.channels_per_pixel <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_ch = (v == CH_RGB) ? 3 : 4;
    endtask

    // stimulus
    initial
    begin
        sb           = new();
        idle_allowed = 1'b1;
        idle_on      = 1'b1;
        hold_left    = 0;
        cur_ch       = 4;
        rst_n                     <= 1'b0;
        byte_if.valid             <= 1'b0;
        byte_if.data_byte         <= 8'd0;
        byte_if.image_start       <= 1'b0;
        cfg_if.valid              <= 1'b0;
        cfg_if.channels_per_pixel <= CH_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_channels(CH_RESET);

        // short images: every filter, a bad one, then recovery
        foreach (OPENING_FILTERS[i])
        begin
            send_byte(OPENING_FILTERS[i], 1'b1);
            for (int k = 0; k < 4; k++)
                send_byte(CORNER_SAMPLES[(i + k) % 4], 1'b0);
        end

        // four bytes per pixel, long output hold-off while bytes keep coming
        hold_left = 400;
        repeat (4) send_image(0, $urandom_range(0, 24), 1'b1);

        // narrow the pixel in the middle of a wide row, then a row with up bytes
        send_image(0, 780, 1'b0);
        write_channels(CH_RGB);
        send_byte(rand_sample(), 1'b0);
        send_row(1'b0, $urandom_range(20, 40), 1'b1);

        // short image without gaps
        idle_allowed = 1'b0;
        idle_on      = 1'b0;
        send_image(0, 30, 1'b0);

        wait_quiet();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== png_scanline_unfilter.f =====
sv/psu_pkg.sv
sv/psu_if.sv
sv/psu_ram.sv
sv/psu_predict.sv
sv/psu_out_buf.sv
sv/png_scanline_unfilter.sv
sv/psu_checker.sv
bench/tb.sv
